// ----- design/pebpm_pkg.sv -----
package pebpm_pkg;

    // Field widths of one item and one result.
    localparam int CMD_W    = 3;
    localparam int BAR_W    = 3;
    localparam int OFF_W    = 16;
    localparam int SIZE_W   = 3;
    localparam int DATA_W   = 32;
    localparam int VEC_W    = 7;
    localparam int STAT_W   = 2;
    localparam int IRQV_W   = 6;
    localparam int IN_W     = 64;
    localparam int OUT_W    = 48;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int BAR_REGS   = 6;
    localparam int BSIZE_W    = 11;
    localparam int NVEC_W     = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_MSIX_VECTORS = 3'd6;

    // Commands.
    localparam logic [CMD_W-1:0] CMD_MMIO_WR  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_MMIO_RD  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CFG_WR   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CFG_RD   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_MSIX_SET = 3'd4;
    localparam logic [CMD_W-1:0] CMD_MSIX_CLR = 3'd5;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_GATED   = 2'd1;
    localparam logic [STAT_W-1:0] ST_INVALID = 2'd2;

    // Power management register and states.
    localparam logic [OFF_W-1:0]  PM_OFFSET = 16'h0044;
    localparam logic [1:0]        PS_D0     = 2'd0;
    localparam logic [1:0]        PS_D3HOT  = 2'd3;

    // What one item leaves for the result stage.
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              use_mem;
        logic [DATA_W-1:0] mask;
        logic [DATA_W-1:0] rdata;
        logic              irq_fire;
        logic [IRQV_W-1:0] irq_vector;
    } stage_t;

    // Byte enable mask for an access of n bytes, n above four saturating.
    function automatic logic [DATA_W-1:0] byte_mask(input logic [SIZE_W-1:0] n);
        logic [DATA_W-1:0] m;
        case (n)
            3'd0:    m = 32'h0000_0000;
            3'd1:    m = 32'h0000_00FF;
            3'd2:    m = 32'h0000_FFFF;
            3'd3:    m = 32'h00FF_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

// ----- design/pebpm_word_store.sv -----
module pebpm_word_store #(
    parameter int DEPTH = 1536,
    parameter int AW    = 11
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         acc_en,
    input  logic                         acc_we,
    input  logic [AW-1:0]                acc_addr,
    input  logic [pebpm_pkg::DATA_W-1:0] acc_wdata,
    output logic [pebpm_pkg::DATA_W-1:0] rdata,
    output logic                         clearing
);

    logic [pebpm_pkg::DATA_W-1:0] mem [0:DEPTH-1];
    logic [AW-1:0]                clr_addr_reg;
    logic [AW-1:0]                clr_addr_next;
    logic                         clearing_reg;
    logic                         clearing_next;
    logic [pebpm_pkg::DATA_W-1:0] rdata_reg;

    // Clearing pass after reset: one word per cycle from the bottom up.
    always_comb begin
        clr_addr_next = clr_addr_reg;
        clearing_next = clearing_reg;
        if (clearing_reg) begin
            clr_addr_next = clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(DEPTH - 1)) begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
            clearing_reg <= 1'b1;
        end else begin
            clr_addr_reg <= clr_addr_next;
            clearing_reg <= clearing_next;
        end
    end

    // Single port word memory with a registered read.
    always_ff @(posedge aclk) begin
        if (clearing_reg) begin
            mem[clr_addr_reg] <= '0;
        end else if (acc_en) begin
            if (acc_we) begin
                mem[acc_addr] <= acc_wdata;
            end else begin
                rdata_reg <= mem[acc_addr];
            end
        end
    end

    assign rdata    = rdata_reg;
    assign clearing = clearing_reg;

endmodule

// ----- design/pcie_endpoint_bar_pm_msix.sv -----
// Mock PCIe endpoint: one word store split into a window per BAR, power state gate and MSI-X pending bits.
// Input channel s_axis_*: one command item per handshake; each item gives exactly
// one result item on m_axis_*, in order. Window sizes and the MSI-X table size are
// written through cfg_we/cfg_index/cfg_wdata while the block is idle.
// Path: an accepted item enters the read stage, which waits for the registered read of
// the word memory, and its result then moves into the output register.
// Throughput: one item per cycle unless clearing or stalled; the single port
// word memory takes one access per cycle and every item uses it at most once,
// at the edge it is accepted. Reset: the gate opens, pending bits and registers
// clear, and a clearing pass writes zero to every one of the store's BAR_COUNT *
// ceil(BAR_BYTES / 4) words (1536 with the defaults), while s_axis_tready stays
// low. Configuration writes are taken during the pass.
// Stall: while m_axis_tready is low the result holds in the output register; one
// more item is accepted into the read stage, then s_axis_tready drops until the
// output register frees.
module pcie_endpoint_bar_pm_msix #(
    parameter int BAR_COUNT   = 6,
    parameter int BAR_BYTES   = 1024,
    parameter int MAX_VECTORS = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Fields from bit 0: command[2:0], bar_index[5:3], offset[21:6],
    // size_bytes[24:22], write_data[56:25], vector[63:57].
    input  logic [pebpm_pkg::IN_W-1:0]       s_axis_tdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // Fields from bit 0: status[1:0], read_data[33:2], irq_fire[34],
    // irq_vector[40:35], zero fill above.
    output logic [pebpm_pkg::OUT_W-1:0]      m_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic                             cfg_we,
    input  logic [pebpm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pebpm_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    localparam int WORDS_PER_BAR = (BAR_BYTES + 3) / 4;
    localparam int DEPTH         = BAR_COUNT * WORDS_PER_BAR;
    localparam int AW            = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int VW            = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1;
    localparam int LIM_W         = 17;
    localparam int TS_W          = 12;

    // Unpacked input fields.
    logic [pebpm_pkg::CMD_W-1:0]  in_cmd;
    logic [pebpm_pkg::BAR_W-1:0]  in_bar;
    logic [pebpm_pkg::OFF_W-1:0]  in_off;
    logic [pebpm_pkg::SIZE_W-1:0] in_size;
    logic [pebpm_pkg::DATA_W-1:0] in_wdata;
    logic [pebpm_pkg::VEC_W-1:0]  in_vec;

    assign in_cmd   = s_axis_tdata[2:0];
    assign in_bar   = s_axis_tdata[5:3];
    assign in_off   = s_axis_tdata[21:6];
    assign in_size  = s_axis_tdata[24:22];
    assign in_wdata = s_axis_tdata[56:25];
    assign in_vec   = s_axis_tdata[63:57];

    // Configuration registers.
    logic [pebpm_pkg::BSIZE_W-1:0] bar_size_reg [0:pebpm_pkg::BAR_REGS-1];
    logic [pebpm_pkg::NVEC_W-1:0]  msix_vectors_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < pebpm_pkg::BAR_REGS; i++) begin
                bar_size_reg[i] <= '0;
            end
            msix_vectors_reg <= '0;
        end else if (cfg_we) begin
            if (cfg_index < pebpm_pkg::CFG_IDX_W'(pebpm_pkg::BAR_REGS)) begin
                bar_size_reg[cfg_index] <= cfg_wdata;
            end else if (cfg_index == pebpm_pkg::CFG_MSIX_VECTORS) begin
                msix_vectors_reg <= cfg_wdata[pebpm_pkg::NVEC_W-1:0];
            end
        end
    end

    // Pipeline handshake.
    logic                     clearing;
    logic                     stage_valid_reg;
    logic                     out_valid_reg;
    logic                     out_free;
    logic                     accept;
    pebpm_pkg::stage_t        stage_reg;
    pebpm_pkg::stage_t        stage_next;
    logic [pebpm_pkg::OUT_W-1:0] out_data_reg;
    logic [pebpm_pkg::OUT_W-1:0] out_data_next;
    logic [pebpm_pkg::DATA_W-1:0] mem_rdata;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !clearing && (!stage_valid_reg || out_free);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Address decode and window check.
    logic [pebpm_pkg::SIZE_W-1:0] size_sat;
    logic [LIM_W-1:0]             bar_lim;
    logic                         bar_ok;
    logic                         loc_ok;
    logic [AW-1:0]                word_addr;
    logic [TS_W-1:0]              vec_limit;
    logic                         vec_ok;
    logic                         gated_reg;
    logic                         gated_next;
    logic [MAX_VECTORS-1:0]       pending_reg;
    logic [MAX_VECTORS-1:0]       pending_next;
    logic                         mem_en;
    logic                         mem_we;

    always_comb begin
        size_sat = (in_size > 3'd4) ? 3'd4 : in_size;
        bar_ok   = (32'(in_bar) < BAR_COUNT) &&
                   (in_bar < pebpm_pkg::BAR_W'(pebpm_pkg::BAR_REGS));
        bar_lim  = '0;
        if (bar_ok) begin
            bar_lim = LIM_W'(bar_size_reg[in_bar]);
        end
        if (bar_lim > LIM_W'(BAR_BYTES)) begin
            bar_lim = LIM_W'(BAR_BYTES);
        end
        loc_ok    = bar_ok && (LIM_W'(in_off) < bar_lim);
        word_addr = AW'(32'(in_bar) * WORDS_PER_BAR + 32'(in_off[pebpm_pkg::OFF_W-1:2]));
        vec_limit = TS_W'(msix_vectors_reg);
        if (vec_limit > TS_W'(MAX_VECTORS)) begin
            vec_limit = TS_W'(MAX_VECTORS);
        end
        vec_ok = TS_W'(in_vec) < vec_limit;
    end

    // Decode of one item: status, side effects and the memory access.
    always_comb begin
        stage_next            = '0;
        stage_next.status     = pebpm_pkg::ST_OK;
        stage_next.mask       = pebpm_pkg::byte_mask(size_sat);
        gated_next            = gated_reg;
        pending_next          = pending_reg;
        mem_en                = 1'b0;
        mem_we                = 1'b0;
        unique case (in_cmd)
            pebpm_pkg::CMD_MMIO_WR: begin
                if (gated_reg) begin
                    stage_next.status = pebpm_pkg::ST_GATED;
                end else if (!loc_ok) begin
                    stage_next.status = pebpm_pkg::ST_INVALID;
                end else begin
                    mem_en = 1'b1;
                    mem_we = 1'b1;
                end
            end
            pebpm_pkg::CMD_MMIO_RD: begin
                if (!loc_ok) begin
                    stage_next.status = pebpm_pkg::ST_INVALID;
                end else begin
                    mem_en             = 1'b1;
                    stage_next.use_mem = 1'b1;
                end
            end
            pebpm_pkg::CMD_CFG_WR: begin
                if (in_off == pebpm_pkg::PM_OFFSET && size_sat != 3'd0) begin
                    if (in_wdata[1:0] == pebpm_pkg::PS_D0) begin
                        gated_next = 1'b0;
                    end else if (in_wdata[1:0] == pebpm_pkg::PS_D3HOT) begin
                        gated_next = 1'b1;
                    end
                end
            end
            pebpm_pkg::CMD_CFG_RD: begin
                if (in_off == pebpm_pkg::PM_OFFSET && size_sat != 3'd0 && gated_reg) begin
                    stage_next.rdata = pebpm_pkg::DATA_W'(pebpm_pkg::PS_D3HOT);
                end
            end
            pebpm_pkg::CMD_MSIX_SET: begin
                if (!vec_ok) begin
                    stage_next.status = pebpm_pkg::ST_INVALID;
                end else begin
                    pending_next[VW'(in_vec)] = 1'b1;
                    stage_next.irq_fire       = 1'b1;
                    stage_next.irq_vector     = in_vec[pebpm_pkg::IRQV_W-1:0];
                end
            end
            pebpm_pkg::CMD_MSIX_CLR: begin
                if (!vec_ok) begin
                    stage_next.status = pebpm_pkg::ST_INVALID;
                end else begin
                    pending_next[VW'(in_vec)] = 1'b0;
                end
            end
            default: begin
                stage_next.status = pebpm_pkg::ST_INVALID;
            end
        endcase
    end

    // Word store with its clearing pass.
    pebpm_word_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .acc_en    (accept && mem_en),
        .acc_we    (mem_we),
        .acc_addr  (word_addr),
        .acc_wdata (in_wdata & stage_next.mask),
        .rdata     (mem_rdata),
        .clearing  (clearing)
    );

    // Endpoint state updates at the accepting edge.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gated_reg   <= 1'b0;
            pending_reg <= '0;
        end else if (accept) begin
            gated_reg   <= gated_next;
            pending_reg <= pending_next;
        end
    end

    // Read stage: waits for the registered memory word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else if (accept) begin
            stage_valid_reg <= 1'b1;
        end else if (out_free) begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            stage_reg <= stage_next;
        end
    end

    // Result assembly into the output register.
    always_comb begin
        logic [pebpm_pkg::DATA_W-1:0] rd;
        rd = stage_reg.use_mem ? (mem_rdata & stage_reg.mask) : stage_reg.rdata;
        out_data_next        = '0;
        out_data_next[1:0]   = stage_reg.status;
        out_data_next[33:2]  = rd;
        out_data_next[34]    = stage_reg.irq_fire;
        out_data_next[40:35] = stage_reg.irq_vector;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= stage_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && stage_valid_reg) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ----- test/tb.sv -----
module tb;

    // Field widths and codes taken from the package.
    localparam int CMD_W      = pebpm_pkg::CMD_W;
    localparam int BAR_W      = pebpm_pkg::BAR_W;
    localparam int OFF_W      = pebpm_pkg::OFF_W;
    localparam int SIZE_W     = pebpm_pkg::SIZE_W;
    localparam int DATA_W     = pebpm_pkg::DATA_W;
    localparam int VEC_W      = pebpm_pkg::VEC_W;
    localparam int STAT_W     = pebpm_pkg::STAT_W;
    localparam int IRQV_W     = pebpm_pkg::IRQV_W;
    localparam int IN_W       = pebpm_pkg::IN_W;
    localparam int OUT_W      = pebpm_pkg::OUT_W;
    localparam int CFG_IDX_W  = pebpm_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = pebpm_pkg::CFG_DATA_W;
    localparam int BSIZE_W    = pebpm_pkg::BSIZE_W;
    localparam int NVEC_W     = pebpm_pkg::NVEC_W;

    localparam logic [CFG_IDX_W-1:0] CFG_MSIX_VECTORS = pebpm_pkg::CFG_MSIX_VECTORS;
    localparam logic [CMD_W-1:0]  CMD_MMIO_WR  = pebpm_pkg::CMD_MMIO_WR;
    localparam logic [CMD_W-1:0]  CMD_MMIO_RD  = pebpm_pkg::CMD_MMIO_RD;
    localparam logic [CMD_W-1:0]  CMD_CFG_WR   = pebpm_pkg::CMD_CFG_WR;
    localparam logic [CMD_W-1:0]  CMD_CFG_RD   = pebpm_pkg::CMD_CFG_RD;
    localparam logic [CMD_W-1:0]  CMD_MSIX_SET = pebpm_pkg::CMD_MSIX_SET;
    localparam logic [CMD_W-1:0]  CMD_MSIX_CLR = pebpm_pkg::CMD_MSIX_CLR;
    localparam logic [STAT_W-1:0] ST_OK        = pebpm_pkg::ST_OK;
    localparam logic [STAT_W-1:0] ST_GATED     = pebpm_pkg::ST_GATED;
    localparam logic [STAT_W-1:0] ST_INVALID   = pebpm_pkg::ST_INVALID;
    localparam logic [OFF_W-1:0]  PM_OFFSET    = pebpm_pkg::PM_OFFSET;
    localparam logic [1:0]        PS_D0        = pebpm_pkg::PS_D0;
    localparam logic [1:0]        PS_D3HOT     = pebpm_pkg::PS_D3HOT;

    // Block defaults that the predictor mirrors, and bench limits.
    localparam int NUM_BARS    = 6;
    localparam int WINDOW_MAX  = 1024;
    localparam int VEC_MAX     = 64;
    localparam int WORDS       = WINDOW_MAX / 4;
    localparam int STALL_LIMIT = 5000;
    localparam int LONG_HOLD   = 300;
    localparam int PHASE_ITEMS = 270;

    // Command codes that the block must reject.
    localparam logic [CMD_W-1:0] CMD_UNUSED6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNUSED7 = 3'd7;

    // One command item, command in the lowest bits.
    typedef struct packed {
        logic [VEC_W-1:0]  vector;
        logic [DATA_W-1:0] write_data;
        logic [SIZE_W-1:0] size_bytes;
        logic [OFF_W-1:0]  offset;
        logic [BAR_W-1:0]  bar_index;
        logic [CMD_W-1:0]  command;
    } ep_cmd_t;

    // One result item, status in the lowest bits.
    typedef struct packed {
        logic [OUT_W-STAT_W-DATA_W-IRQV_W-2:0] fill;
        logic [IRQV_W-1:0] irq_vector;
        logic              irq_fire;
        logic [DATA_W-1:0] read_data;
        logic [STAT_W-1:0] status;
    } ep_resp_t;

    // A directed row; typed rows carry their own expected result.
    typedef struct {
        ep_cmd_t  cmd;
        logic     typed;
        ep_resp_t resp;
    } dir_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic [IN_W-1:0]       s_axis_tdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [OUT_W-1:0]      m_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b1;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Predictor state: word store, power gate, pending table, registers.
    logic [DATA_W-1:0]  bar_mem [0:NUM_BARS-1][0:WORDS-1];
    logic               gate_closed = 1'b0;
    logic [VEC_MAX-1:0] msix_pending = '0;
    logic [BSIZE_W-1:0] window_bytes [0:NUM_BARS-1];
    logic [NVEC_W-1:0]  msix_count = '0;

    // Register values for the next setting.
    logic [BSIZE_W-1:0] next_sizes [0:NUM_BARS-1];
    logic [NVEC_W-1:0]  next_vectors;

    ep_resp_t expected_resp [$];
    dir_row_t dir_rows [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_req = 0;
    int hold_done = 0;
    int mismatches = 0;
    int checked = 0;
    int items_sent = 0;
    int irq_count = 0;
    int gated_count = 0;
    int invalid_count = 0;

    pcie_endpoint_bar_pm_msix uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    // Clock with a period of two time units.
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Usable window of a BAR in bytes; invalid BARs have none.
    function automatic int eff_window(input logic [BAR_W-1:0] bar);
        if (bar >= NUM_BARS) begin
            return 0;
        end
        return (window_bytes[bar] > WINDOW_MAX) ? WINDOW_MAX : int'(window_bytes[bar]);
    endfunction

    // Computes the result of one command and updates the predictor state.
    function automatic ep_resp_t endpoint_response(input ep_cmd_t c);
        ep_resp_t r;
        int sz;
        int tsize;
        logic [DATA_W-1:0] mask;
        r = '0;
        sz = (c.size_bytes > 4) ? 4 : int'(c.size_bytes);
        mask = (sz >= 4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * sz)) - 32'd1);
        tsize = (msix_count > VEC_MAX) ? VEC_MAX : int'(msix_count);
        case (c.command)
            CMD_MMIO_WR: begin
                // The gate refuses writes before any address check.
                if (gate_closed) begin
                    r.status = ST_GATED;
                end else if (c.offset >= eff_window(c.bar_index)) begin
                    r.status = ST_INVALID;
                end else begin
                    bar_mem[c.bar_index][c.offset[9:2]] = c.write_data & mask;
                end
            end
            CMD_MMIO_RD: begin
                if (c.offset >= eff_window(c.bar_index)) begin
                    r.status = ST_INVALID;
                end else begin
                    r.read_data = bar_mem[c.bar_index][c.offset[9:2]] & mask;
                end
            end
            CMD_CFG_WR: begin
                if (c.offset == PM_OFFSET && sz >= 1) begin
                    if (c.write_data[1:0] == PS_D0) begin
                        gate_closed = 1'b0;
                    end else if (c.write_data[1:0] == PS_D3HOT) begin
                        gate_closed = 1'b1;
                    end
                end
            end
            CMD_CFG_RD: begin
                if (c.offset == PM_OFFSET && sz >= 1) begin
                    r.read_data = gate_closed ? 32'(PS_D3HOT) : 32'(PS_D0);
                end
            end
            CMD_MSIX_SET: begin
                if (c.vector >= tsize) begin
                    r.status = ST_INVALID;
                end else begin
                    msix_pending[c.vector[5:0]] = 1'b1;
                    r.irq_fire = 1'b1;
                    r.irq_vector = c.vector[5:0];
                end
            end
            CMD_MSIX_CLR: begin
                if (c.vector >= tsize) begin
                    r.status = ST_INVALID;
                end else begin
                    msix_pending[c.vector[5:0]] = 1'b0;
                end
            end
            default: begin
                r.status = ST_INVALID;
            end
        endcase
        return r;
    endfunction

    // Adds one directed row; typed rows expect no interrupt.
    task automatic add_row(input logic [CMD_W-1:0] cmd, input logic [BAR_W-1:0] bar,
                           input logic [OFF_W-1:0] off, input logic [SIZE_W-1:0] sz,
                           input logic [DATA_W-1:0] wd, input logic [VEC_W-1:0] vec,
                           input int typed, input logic [STAT_W-1:0] st,
                           input logic [DATA_W-1:0] rd);
        dir_row_t row;
        row.cmd = '{vector: vec, write_data: wd, size_bytes: sz, offset: off,
                    bar_index: bar, command: cmd};
        row.typed = (typed != 0);
        row.resp = '0;
        row.resp.status = st;
        row.resp.read_data = rd;
        dir_rows.push_back(row);
    endtask

    // Offers one item, with random idle cycles first, and records its result.
    task automatic offer_command(input ep_cmd_t c, input logic typed,
                                 input ep_resp_t typed_resp);
        ep_resp_t predicted;
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tdata <= c;
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        predicted = endpoint_response(c);
        expected_resp.push_back(typed ? typed_resp : predicted);
        items_sent++;
    endtask

    // Writes all registers from next_sizes and next_vectors.
    task automatic apply_settings();
        int i;
        for (i = 0; i < NUM_BARS; i++) begin
            @(negedge aclk);
            cfg_we <= 1'b1;
            cfg_index <= i[CFG_IDX_W-1:0];
            cfg_wdata <= next_sizes[i];
            window_bytes[i] = next_sizes[i];
        end
        @(negedge aclk);
        cfg_index <= CFG_MSIX_VECTORS;
        cfg_wdata <= CFG_DATA_W'(next_vectors);
        msix_count = next_vectors;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Lets the block drain so that registers can be rewritten.
    task automatic quiesce();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (expected_resp.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Receiver: random stalls, and a long counted hold when one is requested.
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_req != hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                hold_done = hold_done + 1;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Result checker against the oldest expected result.
    always @(posedge aclk) begin : check_blk
        ep_resp_t got;
        ep_resp_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (expected_resp.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Unexpected result %h with nothing outstanding.", got);
                end
            end else begin
                want = expected_resp.pop_front();
                checked++;
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Result %0d: status %0d/%0d data %h/%h irq %b/%b (exp/got)",
                                 checked, want.status, got.status, want.read_data,
                                 got.read_data, want.irq_fire, got.irq_fire);
                        $display("  vec %0d/%0d fill %h/%h (exp/got)",
                                 want.irq_vector, got.irq_vector, want.fill, got.fill);
                    end
                end
                if (got.irq_fire) irq_count++;
                if (got.status == ST_GATED) gated_count++;
                if (got.status == ST_INVALID) invalid_count++;
            end
        end
    end

    // Watchdog on cycles in which no item moves on either side.
    initial begin : watchdog
        int idle_run;
        idle_run = 0;
        while (idle_run < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_run = 0;
            end else begin
                idle_run++;
            end
        end
        $display("Timeout: no item moved for %0d cycles.", STALL_LIMIT);
        $display("FAIL");
        $finish;
    end

    // Main sequence: reset, directed rows, then random phases.
    initial begin
        ep_cmd_t c;
        ep_resp_t no_resp;
        int i, j, ph, n, roll, lim, tsize;
        no_resp = '0;
        for (i = 0; i < NUM_BARS; i++) begin
            window_bytes[i] = '0;
            for (j = 0; j < WORDS; j++) bar_mem[i][j] = '0;
        end

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // First setting: full, tiny, empty, oversized and odd windows.
        next_sizes[0] = 11'd1024;
        next_sizes[1] = 11'd4;
        next_sizes[2] = 11'd0;
        next_sizes[3] = 11'd2047;
        next_sizes[4] = 11'd512;
        next_sizes[5] = 11'd100;
        next_vectors = 7'd64;
        apply_settings();

        // Window edges, bad BARs, zero size, oversized window.
        add_row(CMD_MMIO_RD, 3'd0, 16'd0, 3'd4, 32'h0, 7'd0, 1, ST_OK, 32'h0);
        add_row(CMD_MMIO_WR, 3'd0, 16'd1020, 3'd4, 32'hFFFF_FFFF, 7'd0, 1, ST_OK, 32'h0);
        add_row(CMD_MMIO_RD, 3'd0, 16'd1023, 3'd4, 32'h0, 7'd0, 1, ST_OK, 32'hFFFF_FFFF);
        add_row(CMD_MMIO_RD, 3'd0, 16'd1024, 3'd4, 32'h0, 7'd0, 1, ST_INVALID, 32'h0);
        add_row(CMD_MMIO_RD, 3'd0, 16'd1020, 3'd0, 32'h0, 7'd0, 1, ST_OK, 32'h0);
        add_row(CMD_MMIO_WR, 3'd1, 16'd3, 3'd2, 32'h1234_5678, 7'd0, 1, ST_OK, 32'h0);
        add_row(CMD_MMIO_RD, 3'd1, 16'd0, 3'd7, 32'h0, 7'd0, 1, ST_OK, 32'h0000_5678);
        add_row(CMD_MMIO_RD, 3'd1, 16'd4, 3'd4, 32'h0, 7'd0, 1, ST_INVALID, 32'h0);
        add_row(CMD_MMIO_WR, 3'd2, 16'd0, 3'd4, 32'h5A5A_5A5A, 7'd0, 1, ST_INVALID, 32'h0);
        add_row(CMD_MMIO_WR, 3'd6, 16'd0, 3'd4, 32'h1, 7'd0, 1, ST_INVALID, 32'h0);
        add_row(CMD_MMIO_RD, 3'd7, 16'd0, 3'd4, 32'h0, 7'd0, 1, ST_INVALID, 32'h0);
        add_row(CMD_MMIO_WR, 3'd3, 16'd1023, 3'd0, 32'hFFFF_FFFF, 7'd0, 1, ST_OK, 32'h0);
        add_row(CMD_MMIO_RD, 3'd3, 16'd1020, 3'd4, 32'h0, 7'd0, 0, ST_OK, 32'h0);
        add_row(CMD_MMIO_RD, 3'd3, 16'd1024, 3'd4, 32'h0, 7'd0, 1, ST_INVALID, 32'h0);
        // Power state: zero width ignored, D3hot gates writes, state 2 ignored, D0 reopens.
        add_row(CMD_CFG_RD, 3'd0, PM_OFFSET, 3'd1, 32'h0, 7'd0, 1, ST_OK, 32'h0);
        add_row(CMD_CFG_WR, 3'd0, PM_OFFSET, 3'd0, 32'h3, 7'd0, 1, ST_OK, 32'h0);
        add_row(CMD_CFG_RD, 3'd0, PM_OFFSET, 3'd4, 32'h0, 7'd0, 0, ST_OK, 32'h0);
        add_row(CMD_CFG_WR, 3'd0, PM_OFFSET, 3'd1, 32'hFFFF_FFFF, 7'd0, 1, ST_OK, 32'h0);
        add_row(CMD_MMIO_WR, 3'd7, 16'hFFFF, 3'd4, 32'h1, 7'd0, 1, ST_GATED, 32'h0);
        add_row(CMD_CFG_WR, 3'd0, PM_OFFSET, 3'd2, 32'h2, 7'd0, 0, ST_OK, 32'h0);
        add_row(CMD_CFG_RD, 3'd0, PM_OFFSET, 3'd2, 32'h0, 7'd0, 0, ST_OK, 32'h0);
        add_row(CMD_MMIO_RD, 3'd0, 16'd1020, 3'd3, 32'h0, 7'd0, 0, ST_OK, 32'h0);
        add_row(CMD_CFG_RD, 3'd0, 16'h0040, 3'd4, 32'h0, 7'd0, 1, ST_OK, 32'h0);
        add_row(CMD_CFG_WR, 3'd0, PM_OFFSET, 3'd1, 32'hFFFF_FFFC, 7'd0, 0, ST_OK, 32'h0);
        // Vector range edges and unknown commands.
        add_row(CMD_MSIX_SET, 3'd0, 16'd0, 3'd0, 32'h0, 7'd63, 0, ST_OK, 32'h0);
        add_row(CMD_MSIX_SET, 3'd0, 16'd0, 3'd0, 32'h0, 7'd64, 1, ST_INVALID, 32'h0);
        add_row(CMD_MSIX_CLR, 3'd0, 16'd0, 3'd0, 32'h0, 7'd127, 1, ST_INVALID, 32'h0);
        add_row(CMD_MSIX_CLR, 3'd0, 16'd0, 3'd0, 32'h0, 7'd0, 0, ST_OK, 32'h0);
        add_row(CMD_UNUSED6, 3'd0, 16'd0, 3'd4, 32'h0, 7'd0, 1, ST_INVALID, 32'h0);
        add_row(CMD_UNUSED7, 3'd7, 16'hFFFF, 3'd7, 32'hFFFF_FFFF, 7'd127, 1, ST_INVALID, 32'h0);

        foreach (dir_rows[k]) begin
            offer_command(dir_rows[k].cmd, dir_rows[k].typed, dir_rows[k].resp);
        end

        // Random phases, each under its own register setting and one of four idle patterns.
        for (ph = 0; ph < 6; ph++) begin
            quiesce();
            for (i = 0; i < NUM_BARS; i++) begin
                case (ph)
                    0: next_sizes[i] = 11'd1024;
                    1: next_sizes[i] = BSIZE_W'($urandom_range(64));
                    2: next_sizes[i] = (i % 2 == 0) ? 11'd2047 : ((i == 1) ? 11'd0 : 11'd4);
                    3: next_sizes[i] = BSIZE_W'($urandom_range(2047));
                    4: next_sizes[i] = (i < 3) ? BSIZE_W'(i + 1) : BSIZE_W'(1022 + i);
                    default: next_sizes[i] = BSIZE_W'($urandom_range(1024));
                endcase
            end
            case (ph)
                0: next_vectors = 7'd64;
                1: next_vectors = NVEC_W'($urandom_range(16));
                2: next_vectors = 7'd127;
                3: next_vectors = NVEC_W'($urandom_range(127));
                4: next_vectors = 7'd1;
                default: next_vectors = 7'd0;
            endcase
            apply_settings();
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            if (ph == 5) begin
                send_idle_pct = 32;
                recv_stall_pct = 32;
            end

            for (n = 0; n < PHASE_ITEMS; n++) begin
                // The receiver holds off while items keep coming.
                if (ph == 0 && n == 100) hold_req++;
                roll = $urandom_range(99);
                if (roll < 30) c.command = CMD_MMIO_WR;
                else if (roll < 60) c.command = CMD_MMIO_RD;
                else if (roll < 68) c.command = CMD_CFG_WR;
                else if (roll < 75) c.command = CMD_CFG_RD;
                else if (roll < 87) c.command = CMD_MSIX_SET;
                else if (roll < 98) c.command = CMD_MSIX_CLR;
                else c.command = ($urandom_range(1) != 0) ? CMD_UNUSED7 : CMD_UNUSED6;
                c.bar_index = ($urandom_range(99) < 92) ? BAR_W'($urandom_range(5))
                                                        : BAR_W'($urandom_range(7, 6));
                c.size_bytes = SIZE_W'($urandom_range(7));
                c.write_data = $urandom;
                lim = eff_window(c.bar_index);
                tsize = (msix_count > VEC_MAX) ? VEC_MAX : int'(msix_count);
                roll = $urandom_range(99);
                if (c.command == CMD_CFG_WR || c.command == CMD_CFG_RD) begin
                    if (roll < 70) c.offset = PM_OFFSET;
                    else if (roll < 85) c.offset = OFF_W'(16'h0040 + $urandom_range(7));
                    else c.offset = OFF_W'($urandom);
                end else if (roll < 75 && lim > 0) begin
                    c.offset = OFF_W'($urandom_range(lim - 1));
                end else if (roll < 88) begin
                    c.offset = OFF_W'(lim + $urandom_range(3));
                end else begin
                    c.offset = OFF_W'($urandom);
                end
                c.vector = ($urandom_range(99) < 85) ? VEC_W'($urandom_range(tsize))
                                                     : VEC_W'($urandom);
                offer_command(c, 1'b0, no_resp);
            end
        end

        quiesce();
        repeat (8) @(posedge aclk);

        $display("Sent %0d items (%0d directed) under seven register settings,",
                 items_sent, dir_rows.size());
        $display("four idle patterns and one long receiver hold.");
        $display("Checked %0d results: %0d interrupts, %0d gated, %0d rejected.",
                 checked, irq_count, gated_count, invalid_count);
        if (mismatches == 0 && expected_resp.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
